// ----- rtl/sensor_frame_deframer_core_assert.svh -----
// ---------------------------------------------------------------------------
// Assertion macros for the sensor frame deframer
// Shared concurrent-assertion forms, clocked on the rising edge and
// disabled while the synchronous reset is low.
// ---------------------------------------------------------------------------
`ifndef SENSOR_FRAME_DEFRAMER_CORE_ASSERT_SVH
`define SENSOR_FRAME_DEFRAMER_CORE_ASSERT_SVH

// same-cycle implication
`define SFD_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define SFD_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/sfd_pkg.sv -----
// ---------------------------------------------------------------------------
// sfd_pkg
// Types, codes and lookup functions shared by the deframer modules.
// ---------------------------------------------------------------------------
package sfd_pkg;

  // link framing codes
  localparam logic [7:0] HDR_BYTE  = 8'h9A;
  localparam logic [7:0] CMD_MEAS  = 8'h80;
  localparam logic [7:0] CMD_START = 8'h88;
  localparam logic [7:0] CMD_RESP  = 8'h8F;
  localparam logic [7:0] CMD_TIME  = 8'h93;

  // parameter lengths
  localparam int PARAM_MAX = 22;
  localparam int IDX_W     = 5;
  localparam logic [IDX_W-1:0] LEN_MEAS = IDX_W'(PARAM_MAX);
  localparam logic [IDX_W-1:0] LEN_TIME = 5'd13;
  localparam logic [IDX_W-1:0] LEN_ONE  = 5'd1;
  localparam logic [IDX_W-1:0] LEN_NONE = 5'd0;

  typedef enum logic [2:0] {
    KIND_MEAS    = 3'd0,
    KIND_START   = 3'd1,
    KIND_RESP    = 3'd2,
    KIND_TIME    = 3'd3,
    KIND_UNKNOWN = 3'd4
  } frame_kind_t;

  typedef enum logic [1:0] {
    FR_HUNT,
    FR_CMD,
    FR_BODY
  } front_state_t;

  typedef enum logic {
    TOK_PARAM,
    TOK_END
  } tok_kind_t;

  // classified byte handed from front to back
  typedef struct packed {
    tok_kind_t          kind;
    logic [IDX_W-1:0]   idx;
    logic [7:0]         data;
    frame_kind_t        frame_kind;
    logic               xor_bad;
  } tok_t;

  // one finished frame
  typedef struct packed {
    frame_kind_t         frame_kind;
    logic                checksum_error;
    logic                command_error;
    logic                sticky_error;
    logic [31:0]         tick_time;
    logic signed [23:0]  accel_x;
    logic signed [23:0]  accel_y;
    logic signed [23:0]  accel_z;
    logic signed [23:0]  gyro_x;
    logic signed [23:0]  gyro_y;
    logic signed [23:0]  gyro_z;
  } result_t;

  function automatic logic [IDX_W-1:0] cmd_len(input logic [7:0] cmd);
    logic [IDX_W-1:0] len;
    case (cmd)
      CMD_MEAS:  len = LEN_MEAS;
      CMD_START: len = LEN_ONE;
      CMD_RESP:  len = LEN_ONE;
      CMD_TIME:  len = LEN_TIME;
      default:   len = LEN_NONE;
    endcase
    return len;
  endfunction

  function automatic frame_kind_t cmd_kind(input logic [7:0] cmd);
    frame_kind_t k;
    case (cmd)
      CMD_MEAS:  k = KIND_MEAS;
      CMD_START: k = KIND_START;
      CMD_RESP:  k = KIND_RESP;
      CMD_TIME:  k = KIND_TIME;
      default:   k = KIND_UNKNOWN;
    endcase
    return k;
  endfunction

endpackage

// ----- rtl/sfd_front.sv -----
// ---------------------------------------------------------------------------
// sfd_front
// Byte parser: hunts for the header, decodes the command, numbers the
// parameter bytes and checks the running XOR at the checksum byte.
// ---------------------------------------------------------------------------
module sfd_front (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          byte_take,
  input  logic [7:0]    rx_byte,
  output logic          tok_vld,
  output sfd_pkg::tok_t tok
);

  sfd_pkg::front_state_t              state_r, state_nxt;
  logic [7:0]                         xor_r, xor_nxt;
  logic [sfd_pkg::IDX_W-1:0]          len_r, len_nxt;
  logic [sfd_pkg::IDX_W-1:0]          cnt_r, cnt_nxt;
  sfd_pkg::frame_kind_t               kind_r, kind_nxt;

  // state register; payload needs no reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= sfd_pkg::FR_HUNT;
    end else begin
      state_r <= state_nxt;
    end
    xor_r  <= xor_nxt;
    len_r  <= len_nxt;
    cnt_r  <= cnt_nxt;
    kind_r <= kind_nxt;
  end

  // next state and token classification
  always_comb begin
    state_nxt      = state_r;
    xor_nxt        = xor_r;
    len_nxt        = len_r;
    cnt_nxt        = cnt_r;
    kind_nxt       = kind_r;
    tok_vld        = 1'b0;
    tok.kind       = sfd_pkg::TOK_PARAM;
    tok.idx        = cnt_r;
    tok.data       = rx_byte;
    tok.frame_kind = kind_r;
    tok.xor_bad    = 1'b0;
    case (state_r)
      sfd_pkg::FR_HUNT: begin
        if (byte_take && (rx_byte == sfd_pkg::HDR_BYTE)) begin
          state_nxt = sfd_pkg::FR_CMD;
          xor_nxt   = rx_byte;
        end
      end
      sfd_pkg::FR_CMD: begin
        if (byte_take) begin
          state_nxt = sfd_pkg::FR_BODY;
          xor_nxt   = xor_r ^ rx_byte;
          len_nxt   = sfd_pkg::cmd_len(rx_byte);
          kind_nxt  = sfd_pkg::cmd_kind(rx_byte);
          cnt_nxt   = '0;
        end
      end
      sfd_pkg::FR_BODY: begin
        if (byte_take) begin
          tok_vld = 1'b1;
          xor_nxt = xor_r ^ rx_byte;
          if (cnt_r != len_r) begin
            cnt_nxt = cnt_r + 1'b1;
          end else begin
            // checksum byte closes the frame
            tok.kind    = sfd_pkg::TOK_END;
            tok.xor_bad = ((xor_r ^ rx_byte) != 8'h00);
            state_nxt   = sfd_pkg::FR_HUNT;
          end
        end
      end
      default: begin
        state_nxt = sfd_pkg::FR_HUNT;
      end
    endcase
  end

endmodule

// ----- rtl/sfd_tokq.sv -----
// ---------------------------------------------------------------------------
// sfd_tokq
// Short token queue between the parser and the frame builder.
// ---------------------------------------------------------------------------
module sfd_tokq #(
  parameter int DEPTH = 4
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  sfd_pkg::tok_t push_data,
  input  logic          pop,
  output logic          full,
  output logic          vld,
  output sfd_pkg::tok_t head
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  sfd_pkg::tok_t   q_r [DEPTH];
  logic [AW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]   cnt_r, cnt_nxt;
  logic            do_push, do_pop;

  assign full    = (cnt_r == CW'(DEPTH));
  assign vld     = (cnt_r != '0);
  assign head    = q_r[rd_ptr_r];
  assign do_push = push && !full;
  assign do_pop  = pop && vld;

  // pointer and count update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    case ({do_push, do_pop})
      2'b10:   cnt_nxt = cnt_r + 1'b1;
      2'b01:   cnt_nxt = cnt_r - 1'b1;
      default: cnt_nxt = cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
    if (do_push) begin
      q_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

// ----- rtl/sfd_back.sv -----
// ---------------------------------------------------------------------------
// sfd_back
// Frame builder: stores parameter bytes, forms the result at the end
// token, keeps the sticky error and holds results in an output queue.
// ---------------------------------------------------------------------------
module sfd_back #(
  parameter int OUTQ_DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             tok_vld,
  input  sfd_pkg::tok_t    tok,
  output logic             tok_pop,
  input  logic             res_pop,
  output logic             res_empty,
  output sfd_pkg::result_t res_head
);

  `include "sensor_frame_deframer_core_assert.svh"

  localparam int AW = (OUTQ_DEPTH > 1) ? $clog2(OUTQ_DEPTH) : 1;
  localparam int CW = $clog2(OUTQ_DEPTH + 1);

  logic [7:0]        store_r [sfd_pkg::PARAM_MAX];
  sfd_pkg::result_t  oq_r [OUTQ_DEPTH];
  logic [AW-1:0]     wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0]     rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]     cnt_r, cnt_nxt;
  logic              err_latch_r, err_latch_nxt;
  logic              oq_full, res_push, res_take;
  logic              good_meas;
  sfd_pkg::result_t  res;

  assign oq_full   = (cnt_r == CW'(OUTQ_DEPTH));
  assign res_empty = (cnt_r == '0);
  assign res_head  = oq_r[rd_ptr_r];
  assign res_take  = res_pop && !res_empty;

  // parameter tokens always drain; end tokens wait for queue room
  assign tok_pop  = tok_vld && ((tok.kind == sfd_pkg::TOK_PARAM) || !oq_full);
  assign res_push = tok_pop && (tok.kind == sfd_pkg::TOK_END);

  // result formation
  assign good_meas = !tok.xor_bad && (tok.frame_kind == sfd_pkg::KIND_MEAS);
  always_comb begin
    res.frame_kind     = tok.frame_kind;
    res.checksum_error = tok.xor_bad;
    res.command_error  = !tok.xor_bad && (tok.frame_kind == sfd_pkg::KIND_RESP)
                         && (store_r[0] != 8'h00);
    res.sticky_error   = err_latch_r || res.checksum_error || res.command_error;
    res.tick_time      = '0;
    res.accel_x        = '0;
    res.accel_y        = '0;
    res.accel_z        = '0;
    res.gyro_x         = '0;
    res.gyro_y         = '0;
    res.gyro_z         = '0;
    if (good_meas) begin
      res.tick_time = {store_r[3], store_r[2], store_r[1], store_r[0]};
      res.accel_x   = {store_r[6], store_r[5], store_r[4]};
      res.accel_y   = {store_r[9], store_r[8], store_r[7]};
      res.accel_z   = {store_r[12], store_r[11], store_r[10]};
      res.gyro_x    = {store_r[15], store_r[14], store_r[13]};
      res.gyro_y    = {store_r[18], store_r[17], store_r[16]};
      res.gyro_z    = {store_r[21], store_r[20], store_r[19]};
    end
  end

  // output queue bookkeeping and sticky error
  always_comb begin
    wr_ptr_nxt    = wr_ptr_r;
    rd_ptr_nxt    = rd_ptr_r;
    err_latch_nxt = err_latch_r;
    if (res_push) begin
      wr_ptr_nxt    = (wr_ptr_r == AW'(OUTQ_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      err_latch_nxt = res.sticky_error;
    end
    if (res_take) begin
      rd_ptr_nxt = (rd_ptr_r == AW'(OUTQ_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    case ({res_push, res_take})
      2'b10:   cnt_nxt = cnt_r + 1'b1;
      2'b01:   cnt_nxt = cnt_r - 1'b1;
      default: cnt_nxt = cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r    <= '0;
      rd_ptr_r    <= '0;
      cnt_r       <= '0;
      err_latch_r <= 1'b0;
    end else begin
      wr_ptr_r    <= wr_ptr_nxt;
      rd_ptr_r    <= rd_ptr_nxt;
      cnt_r       <= cnt_nxt;
      err_latch_r <= err_latch_nxt;
    end
    if (tok_pop && (tok.kind == sfd_pkg::TOK_PARAM)
        && (tok.idx < sfd_pkg::IDX_W'(sfd_pkg::PARAM_MAX))) begin
      store_r[tok.idx] <= tok.data;
    end
    if (res_push) begin
      oq_r[wr_ptr_r] <= res;
    end
  end

  // checks
  `SFD_ASSERT_IMP(a_bad_sum_clean, clk, rst_n,
    res_push && res.checksum_error,
    !res.command_error && (res.tick_time == '0) && res.sticky_error,
    "checksum failure carried payload or command error")
  `SFD_ASSERT_NXT(a_sticky_holds, clk, rst_n, err_latch_r, err_latch_r,
    "sticky error cleared")
  `SFD_ASSERT_NXT(a_full_no_push, clk, rst_n, oq_full && !res_pop,
    oq_full && ($past(res_head) == res_head),
    "output queue changed while full and stalled")

endmodule

// ----- rtl/sensor_frame_deframer_core.sv -----
// ---------------------------------------------------------------------------
// sensor_frame_deframer_core
// Parses a received byte stream of sensor-link frames into one result
// per frame.
// ---------------------------------------------------------------------------
// Usage:
//   Input queue side: drive in_rx_byte and raise push; a byte is taken at
//   a rising edge with push high and full low. Bytes outside a frame are
//   dropped until the 0x9A header.
//   Result queue side: while empty is low the oldest frame result is on
//   the out_ ports; raise pop to take it.
//   Throughput: one byte per cycle. The parser never stalls on its own;
//   full rises only when the token queue fills, which happens only when
//   the result queue is full and the receiver does not pop.
//   An end token is registered in the token queue, its result in the result
//   queue; tokens drain one per cycle, an end token only while it has room.
//   Reset (rst_n low at a clock edge) returns the parser to header hunt,
//   empties both queues and clears the sticky error.
//   A stalled receiver holds results in the result queue; the token queue
//   keeps absorbing bytes until it is full as well.
// ---------------------------------------------------------------------------
module sensor_frame_deframer_core #(
  parameter int TOKQ_DEPTH = 4,
  parameter int OUTQ_DEPTH = 2
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  output logic               full,
  input  logic [7:0]         in_rx_byte,
  output logic               empty,
  input  logic               pop,
  output logic [2:0]         out_frame_kind,
  output logic               out_checksum_error,
  output logic               out_command_error,
  output logic               out_sticky_error,
  output logic [31:0]        out_tick_time,
  output logic signed [23:0] out_accel_x,
  output logic signed [23:0] out_accel_y,
  output logic signed [23:0] out_accel_z,
  output logic signed [23:0] out_gyro_x,
  output logic signed [23:0] out_gyro_y,
  output logic signed [23:0] out_gyro_z
);

  logic              byte_take;
  logic              ftok_vld;
  sfd_pkg::tok_t     ftok;
  logic              btok_vld, btok_pop;
  sfd_pkg::tok_t     btok;
  sfd_pkg::result_t  res;

  assign byte_take = push && !full;

  sfd_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .byte_take (byte_take),
    .rx_byte   (in_rx_byte),
    .tok_vld   (ftok_vld),
    .tok       (ftok)
  );

  sfd_tokq #(
    .DEPTH (TOKQ_DEPTH)
  ) u_tokq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (ftok_vld),
    .push_data (ftok),
    .pop       (btok_pop),
    .full      (full),
    .vld       (btok_vld),
    .head      (btok)
  );

  sfd_back #(
    .OUTQ_DEPTH (OUTQ_DEPTH)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .tok_vld   (btok_vld),
    .tok       (btok),
    .tok_pop   (btok_pop),
    .res_pop   (pop),
    .res_empty (empty),
    .res_head  (res)
  );

  // result fields
  assign out_frame_kind     = res.frame_kind;
  assign out_checksum_error = res.checksum_error;
  assign out_command_error  = res.command_error;
  assign out_sticky_error   = res.sticky_error;
  assign out_tick_time      = res.tick_time;
  assign out_accel_x        = res.accel_x;
  assign out_accel_y        = res.accel_y;
  assign out_accel_z        = res.accel_z;
  assign out_gyro_x         = res.gyro_x;
  assign out_gyro_y         = res.gyro_y;
  assign out_gyro_z         = res.gyro_z;

endmodule

// ----- test/sfd_frame_checker.sv -----
// ---------------------------------------------------------------------------
// sfd_frame_checker
// Watches both queue ports of the deframer, rebuilds every expected frame
// result from the accepted byte stream and compares each popped result,
// field by field, against the oldest expected frame.
// ---------------------------------------------------------------------------
module sfd_frame_checker import sfd_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  logic               full,
  input  logic [7:0]         in_rx_byte,
  input  logic               empty,
  input  logic               pop,
  input  logic [2:0]         out_frame_kind,
  input  logic               out_checksum_error,
  input  logic               out_command_error,
  input  logic               out_sticky_error,
  input  logic [31:0]        out_tick_time,
  input  logic signed [23:0] out_accel_x,
  input  logic signed [23:0] out_accel_y,
  input  logic signed [23:0] out_accel_z,
  input  logic signed [23:0] out_gyro_x,
  input  logic signed [23:0] out_gyro_y,
  input  logic signed [23:0] out_gyro_z,
  output int unsigned        fail_count,
  output int unsigned        outstanding
);
  timeunit 1ns;
  timeprecision 1ps;

  // parser shadow state
  logic             framing;
  logic             cmd_seen;
  logic [7:0]       cur_cmd;
  frame_kind_t      cur_kind;
  logic [IDX_W-1:0] remain;
  int unsigned      wr_idx;
  logic [7:0]       xor_acc;
  logic [7:0]       frame_params [PARAM_MAX];
  logic             sticky;

  result_t     expected_frames [$];
  int unsigned mismatch_cnt = 0;
  int unsigned frames_checked = 0;

  assign fail_count = mismatch_cnt;

  function automatic logic signed [23:0] le24(input int unsigned base);
    return {frame_params[base+2], frame_params[base+1], frame_params[base]};
  endfunction

  task automatic note_failure(input string msg);
    mismatch_cnt++;
    if (mismatch_cnt <= 10) begin
      $display("[%0t] %s", $realtime, msg);
    end
  endtask

  task automatic check_field(input string field, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      note_failure($sformatf("frame %0d %s: expected 0x%0h, got 0x%0h",
                             frames_checked, field, want, got));
    end
  endtask

  // advance the shadow parser by one accepted byte
  task automatic take_byte(input logic [7:0] b);
    result_t fr;
    if (!framing) begin
      if (b == HDR_BYTE) begin
        framing  = 1'b1;
        cmd_seen = 1'b0;
        remain   = LEN_NONE;
        xor_acc  = b;
      end
      return;
    end
    xor_acc ^= b;

    // command byte fixes body length and kind
    if (!cmd_seen) begin
      cmd_seen = 1'b1;
      cur_cmd  = b;
      wr_idx   = 0;
      case (b)
        CMD_MEAS: begin
          remain = LEN_MEAS;
          cur_kind = KIND_MEAS;
        end
        CMD_START: begin
          remain = LEN_ONE;
          cur_kind = KIND_START;
        end
        CMD_RESP: begin
          remain = LEN_ONE;
          cur_kind = KIND_RESP;
        end
        CMD_TIME: begin
          remain = LEN_TIME;
          cur_kind = KIND_TIME;
        end
        default: begin
          remain = LEN_NONE;
          cur_kind = KIND_UNKNOWN;
        end
      endcase
      return;
    end

    // parameter bytes
    if (remain != LEN_NONE) begin
      if (wr_idx < PARAM_MAX) frame_params[wr_idx] = b;
      wr_idx++;
      remain--;
      return;
    end

    // checksum byte closes the frame
    framing  = 1'b0;
    cmd_seen = 1'b0;
    fr = '0;
    fr.frame_kind = cur_kind;
    if (xor_acc != 8'h00) begin
      sticky = 1'b1;
      fr.checksum_error = 1'b1;
    end else if (cur_cmd == CMD_RESP) begin
      if (frame_params[0] != 8'h00) begin
        sticky = 1'b1;
        fr.command_error = 1'b1;
      end
    end else if (cur_cmd == CMD_MEAS) begin
      fr.tick_time = {frame_params[3], frame_params[2], frame_params[1], frame_params[0]};
      fr.accel_x = le24(4);
      fr.accel_y = le24(7);
      fr.accel_z = le24(10);
      fr.gyro_x  = le24(13);
      fr.gyro_y  = le24(16);
      fr.gyro_z  = le24(19);
    end
    fr.sticky_error = sticky;
    expected_frames.push_back(fr);
  endtask

  // sample both channels on every rising edge
  always @(posedge clk) begin
    result_t want;
    if (!rst_n) begin
      framing  = 1'b0;
      cmd_seen = 1'b0;
      cur_cmd  = 8'h00;
      cur_kind = KIND_UNKNOWN;
      remain   = LEN_NONE;
      wr_idx   = 0;
      xor_acc  = 8'h00;
      sticky   = 1'b0;
      frame_params = '{default: 8'h00};
      expected_frames.delete();
      outstanding <= 0;
    end else begin
      if (push && !full) take_byte(in_rx_byte);
      if (pop && !empty) begin
        if (expected_frames.size() == 0) begin
          note_failure($sformatf("unexpected result transaction, kind %0d", out_frame_kind));
        end else begin
          want = expected_frames.pop_front();
          check_field("frame_kind", want.frame_kind, out_frame_kind);
          check_field("checksum_error", want.checksum_error, out_checksum_error);
          check_field("command_error", want.command_error, out_command_error);
          check_field("sticky_error", want.sticky_error, out_sticky_error);
          check_field("tick_time", want.tick_time, out_tick_time);
          check_field("accel_x", want.accel_x, out_accel_x);
          check_field("accel_y", want.accel_y, out_accel_y);
          check_field("accel_z", want.accel_z, out_accel_z);
          check_field("gyro_x", want.gyro_x, out_gyro_x);
          check_field("gyro_y", want.gyro_y, out_gyro_y);
          check_field("gyro_z", want.gyro_z, out_gyro_z);
          frames_checked++;
        end
      end
      outstanding <= expected_frames.size();
    end
  end

endmodule

// ----- test/tb.sv -----
// ---------------------------------------------------------------------------
// tb
// Regression for sensor_frame_deframer_core: feeds directed and random
// sensor-link frames (good, corrupted, truncated, noise) with random
// gaps on both queue ports; the frame checker scores every result.
// ---------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import sfd_pkg::*;

  localparam int ITEM_TARGET  = 1100;
  localparam int IDLE_LIMIT   = 1000;
  localparam int DRAIN_CYCLES = 20;

  // parameter fill patterns
  typedef enum int {
    PAT_RANDOM,
    PAT_ZERO,
    PAT_ONES,
    PAT_EXTREME,
    PAT_HEADER
  } fill_t;

  logic               clk = 1'b0;
  logic               rst_n;
  logic               push;
  logic               full;
  logic [7:0]         in_rx_byte;
  logic               empty;
  logic               pop;
  logic [2:0]         out_frame_kind;
  logic               out_checksum_error;
  logic               out_command_error;
  logic               out_sticky_error;
  logic [31:0]        out_tick_time;
  logic signed [23:0] out_accel_x;
  logic signed [23:0] out_accel_y;
  logic signed [23:0] out_accel_z;
  logic signed [23:0] out_gyro_x;
  logic signed [23:0] out_gyro_y;
  logic signed [23:0] out_gyro_z;

  int unsigned fail_count;
  int unsigned outstanding;
  int unsigned idle_cycles = 0;
  int unsigned frame_items = 0;
  bit          send_steady = 1'b0;
  bit          take_steady = 1'b0;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  sensor_frame_deframer_core u_dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .push               (push),
    .full               (full),
    .in_rx_byte         (in_rx_byte),
    .empty              (empty),
    .pop                (pop),
    .out_frame_kind     (out_frame_kind),
    .out_checksum_error (out_checksum_error),
    .out_command_error  (out_command_error),
    .out_sticky_error   (out_sticky_error),
    .out_tick_time      (out_tick_time),
    .out_accel_x        (out_accel_x),
    .out_accel_y        (out_accel_y),
    .out_accel_z        (out_accel_z),
    .out_gyro_x         (out_gyro_x),
    .out_gyro_y         (out_gyro_y),
    .out_gyro_z         (out_gyro_z)
  );

  sfd_frame_checker u_checker (
    .clk                (clk),
    .rst_n              (rst_n),
    .push               (push),
    .full               (full),
    .in_rx_byte         (in_rx_byte),
    .empty              (empty),
    .pop                (pop),
    .out_frame_kind     (out_frame_kind),
    .out_checksum_error (out_checksum_error),
    .out_command_error  (out_command_error),
    .out_sticky_error   (out_sticky_error),
    .out_tick_time      (out_tick_time),
    .out_accel_x        (out_accel_x),
    .out_accel_y        (out_accel_y),
    .out_accel_z        (out_accel_z),
    .out_gyro_x         (out_gyro_x),
    .out_gyro_y         (out_gyro_y),
    .out_gyro_z         (out_gyro_z),
    .fail_count         (fail_count),
    .outstanding        (outstanding)
  );

  // one byte transaction; push stays high across back-to-back bytes
  task automatic send_byte(input logic [7:0] b);
    int unsigned gap;
    gap = send_steady ? 0 : $urandom_range(0, 5);
    if (gap != 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    push <= 1'b1;
    in_rx_byte <= b;
    @(posedge clk);
    while (full) @(posedge clk);
  endtask

  // header, command, n_par parameters, checksum; keep = 0 sends it whole,
  // otherwise only the first keep bytes go out
  task automatic send_frame(input logic [7:0] cmd, input int unsigned n_par,
                            input fill_t pat, input bit corrupt,
                            input int unsigned keep);
    logic [7:0]  fb [PARAM_MAX+3];
    logic [7:0]  sum;
    int unsigned total;
    int unsigned k;
    fb[0] = HDR_BYTE;
    fb[1] = cmd;
    sum = HDR_BYTE ^ cmd;
    for (int unsigned i = 0; i < n_par; i++) begin
      case (pat)
        PAT_ZERO:   fb[i+2] = 8'h00;
        PAT_ONES:   fb[i+2] = 8'hFF;
        PAT_HEADER: fb[i+2] = HDR_BYTE;
        // samples alternate between most positive and most negative
        PAT_EXTREME: begin
          if (i < 4) fb[i+2] = 8'($urandom_range(0, 255));
          else if ((i - 4) % 3 == 2) fb[i+2] = (((i - 4) / 3) % 2) ? 8'h80 : 8'h7F;
          else fb[i+2] = (((i - 4) / 3) % 2) ? 8'h00 : 8'hFF;
        end
        default:    fb[i+2] = 8'($urandom_range(0, 255));
      endcase
      sum ^= fb[i+2];
    end
    if (corrupt) sum ^= 8'($urandom_range(1, 255));
    fb[n_par+2] = sum;
    total = n_par + 3;
    k = (keep == 0 || keep > total) ? total : keep;
    for (int unsigned i = 0; i < k; i++) send_byte(fb[i]);
    frame_items += k;
  endtask

  // hold off the sender until every expected result has been popped
  task automatic wait_for_results();
    push <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  // result side: random pop gaps with steady stretches
  initial begin
    int unsigned gap;
    int unsigned run;
    run = 0;
    pop <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (run == 0) begin
        take_steady = ($urandom_range(0, 3) == 0);
        run = $urandom_range(10, 40);
      end
      run--;
      gap = take_steady ? 0 : $urandom_range(0, 5);
      if (gap != 0) begin
        pop <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      pop <= 1'b1;
      @(posedge clk);
      while (empty) @(posedge clk);
    end
  end

  // watchdog on cycles with no transaction on either port
  always @(posedge clk) begin
    if (rst_n) begin
      if ((push && !full) || (pop && !empty)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
        $display("timeout: no transaction for %0d cycles", IDLE_LIMIT);
        $display("sensor_frame_deframer_core regression: fail");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  // stimulus and verdict
  initial begin
    int unsigned choice;
    logic [7:0]  cmd;
    bit          corrupt;
    fill_t       pat;
    rst_n      <= 1'b0;
    push       <= 1'b0;
    in_rx_byte <= 8'h00;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // directed: noise before a header, every short frame, special cases
    send_byte(8'h00);
    send_byte(8'hFF);
    send_frame(8'h00, 0, PAT_ZERO, 1'b0, 0);       // unknown command
    send_frame(CMD_START, 1, PAT_RANDOM, 1'b0, 0);
    send_frame(CMD_RESP, 1, PAT_ZERO, 1'b0, 0);    // good status
    wait_for_results();
    send_frame(CMD_RESP, 1, PAT_ONES, 1'b0, 0);    // status error, sets sticky
    send_frame(CMD_START, 1, PAT_RANDOM, 1'b1, 0); // bad checksum
    send_frame(CMD_START, 1, PAT_HEADER, 1'b0, 0); // header value as data
    send_frame(HDR_BYTE, 0, PAT_ZERO, 1'b0, 0);    // header value as command

    // long frames with extreme content first
    send_steady = 1'b1;
    send_frame(CMD_MEAS, PARAM_MAX, PAT_EXTREME, 1'b0, 0);
    send_steady = 1'b0;
    send_frame(CMD_MEAS, PARAM_MAX, PAT_ONES, 1'b0, 0);
    send_frame(CMD_MEAS, PARAM_MAX, PAT_ZERO, 1'b0, 0);
    send_frame(CMD_TIME, LEN_TIME, PAT_RANDOM, 1'b0, 0);

    // random frames, mostly well formed
    while (frame_items < ITEM_TARGET) begin
      choice = $urandom_range(0, 99);
      send_steady = ($urandom_range(0, 5) == 0);
      corrupt = ($urandom_range(0, 9) == 0);
      pat = ($urandom_range(0, 3) == 0) ? fill_t'($urandom_range(1, 4)) : PAT_RANDOM;
      if (choice < 30) begin
        send_frame(CMD_MEAS, PARAM_MAX, pat, corrupt, 0);
      end else if (choice < 45) begin
        send_frame(CMD_START, 1, pat, corrupt, 0);
      end else if (choice < 62) begin
        send_frame(CMD_RESP, 1, $urandom_range(0, 1) ? PAT_ZERO : PAT_RANDOM, corrupt, 0);
      end else if (choice < 77) begin
        send_frame(CMD_TIME, LEN_TIME, pat, corrupt, 0);
      end else if (choice < 87) begin
        do cmd = 8'($urandom_range(0, 255));
        while (cmd == CMD_MEAS || cmd == CMD_START || cmd == CMD_RESP || cmd == CMD_TIME);
        send_frame(cmd, 0, PAT_RANDOM, corrupt, 0);
      end else if (choice < 93) begin
        // cut short; the next header lands inside this frame
        send_frame(CMD_MEAS, PARAM_MAX, pat, 1'b0, $urandom_range(1, PARAM_MAX + 2));
      end else begin
        // line noise between frames
        repeat ($urandom_range(1, 4)) send_byte(8'($urandom_range(0, 255)));
      end
      if ($urandom_range(0, 49) == 0) wait_for_results();
    end

    wait_for_results();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0 && outstanding == 0) begin
      $display("sensor_frame_deframer_core regression: pass");
    end else begin
      $display("sensor_frame_deframer_core regression: fail");
    end
    $finish;
  end

endmodule
